[rtl/rxu_pkg.sv]
// shared constants, opcode codes and record types for the execute unit
// no dependencies; compiled first

package rxu_pkg;

  localparam int XLEN      = 32;
  localparam int REG_COUNT = 16;
  localparam int REG_AW    = $clog2(REG_COUNT);
  // word count must be a power of two: the address wraps by truncation
  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int IO_COUNT  = 22;
  localparam int IO_AW     = $clog2(IO_COUNT);
  localparam int PC_BITS   = 10;

  localparam logic [REG_AW-1:0] REG_ZERO      = REG_AW'(0);
  localparam logic [REG_AW-1:0] REG_IMM       = REG_AW'(1);
  localparam logic [REG_AW-1:0] RA_REG        = REG_AW'(15);
  localparam logic [IO_AW-1:0]  IRQ_RETURN_IO = IO_AW'(7);

  typedef enum logic [7:0] {
    OP_ADD  = 8'd0,
    OP_SUB  = 8'd1,
    OP_AND  = 8'd2,
    OP_OR   = 8'd3,
    OP_XOR  = 8'd4,
    OP_MUL  = 8'd5,
    OP_SLL  = 8'd6,
    OP_SRA  = 8'd7,
    OP_SRL  = 8'd8,
    OP_BEQ  = 8'd9,
    OP_BNE  = 8'd10,
    OP_BLT  = 8'd11,
    OP_BGT  = 8'd12,
    OP_BLE  = 8'd13,
    OP_BGE  = 8'd14,
    OP_JAL  = 8'd15,
    OP_LW   = 8'd16,
    OP_SW   = 8'd17,
    OP_RETI = 8'd18,
    OP_IN   = 8'd19,
    OP_OUT  = 8'd20,
    OP_HALT = 8'd21
  } op_t;

  // one register file write
  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } wb_t;

  // decoded outcome of one instruction in the execute stage
  typedef struct packed {
    logic [XLEN-1:0]    res;
    logic               rd_we;
    logic [REG_AW-1:0]  rd;
    logic [PC_BITS-1:0] next_pc;
    logic               taken;
    logic               halted;
    logic               leave;
    logic               is_load;
    logic               is_store;
    logic               is_in;
    logic               is_out;
    logic               io_ok;
    logic [XLEN-1:0]    sum;
  } exec_t;

endpackage

[rtl/rxu_in_if.sv]
// instruction channel: valid/ready handshake with decoded instruction fields
// depends on rxu_pkg

interface rxu_in_if;
  import rxu_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [7:0]                cmd;
  logic [REG_AW-1:0]         dest_reg;
  logic [REG_AW-1:0]         src_reg_a;
  logic [REG_AW-1:0]         src_reg_b;
  logic signed [XLEN-1:0]    immediate;
  logic [PC_BITS-1:0]        pc_value;

  modport source (
    output valid, cmd, dest_reg, src_reg_a, src_reg_b, immediate, pc_value,
    input  ready
  );

  modport sink (
    input  valid, cmd, dest_reg, src_reg_a, src_reg_b, immediate, pc_value,
    output ready
  );
endinterface

[rtl/rxu_out_if.sv]
// result channel: valid/ready handshake with counter and status flags
// depends on rxu_pkg

interface rxu_out_if;
  import rxu_pkg::*;

  logic               valid;
  logic               ready;
  logic [PC_BITS-1:0] next_pc;
  logic               branch_taken;
  logic               halted;
  logic               leave_interrupt;

  modport source (
    output valid, next_pc, branch_taken, halted, leave_interrupt,
    input  ready
  );

  modport sink (
    input  valid, next_pc, branch_taken, halted, leave_interrupt,
    output ready
  );
endinterface

[rtl/rxu_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies

module rxu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read returns the old word on a same-cycle write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/rxu_regfile.sv]
// general register file: three read copies, reset valid bits, forwarding
// depends on rxu_pkg and rxu_ram

module rxu_regfile (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [rxu_pkg::REG_AW-1:0] rs_addr,
  input  logic [rxu_pkg::REG_AW-1:0] rt_addr,
  input  logic [rxu_pkg::REG_AW-1:0] rd_addr,
  input  logic [rxu_pkg::XLEN-1:0] imm,
  input  rxu_pkg::wb_t             wb,
  input  rxu_pkg::wb_t             fwd,
  output logic [rxu_pkg::XLEN-1:0] a_val,
  output logic [rxu_pkg::XLEN-1:0] b_val,
  output logic [rxu_pkg::XLEN-1:0] d_val
);
  import rxu_pkg::*;

  logic [REG_COUNT-1:0] reg_vld_r;
  logic [REG_AW-1:0]    rs_r, rt_r, rd_r;
  logic                 vld_a_r, vld_b_r, vld_d_r;
  wb_t                  last_wb_r;
  logic [XLEN-1:0]      raw_a, raw_b, raw_d;

  rxu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram_a (
    .clk(clk), .we(wb.we), .waddr(wb.addr), .wdata(wb.data),
    .re(rd_en), .raddr(rs_addr), .rdata(raw_a)
  );
  rxu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram_b (
    .clk(clk), .we(wb.we), .waddr(wb.addr), .wdata(wb.data),
    .re(rd_en), .raddr(rt_addr), .rdata(raw_b)
  );
  rxu_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_ram_d (
    .clk(clk), .we(wb.we), .waddr(wb.addr), .wdata(wb.data),
    .re(rd_en), .raddr(rd_addr), .rdata(raw_d)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_vld_r    <= '0;
      last_wb_r.we <= 1'b0;
    end else begin
      if (wb.we) begin
        reg_vld_r[wb.addr] <= 1'b1;
        last_wb_r.we       <= 1'b1;
        last_wb_r.addr     <= wb.addr;
        last_wb_r.data     <= wb.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rs_r    <= rs_addr;
      rt_r    <= rt_addr;
      rd_r    <= rd_addr;
      vld_a_r <= reg_vld_r[rs_addr];
      vld_b_r <= reg_vld_r[rt_addr];
      vld_d_r <= reg_vld_r[rd_addr];
    end
  end

  // pending write first, then the write that retired alongside the read
  function automatic logic [XLEN-1:0] resolve(
    input logic [REG_AW-1:0] addr,
    input logic [XLEN-1:0]   raw,
    input logic              vld,
    input logic [XLEN-1:0]   imm_v,
    input wb_t               pend,
    input wb_t               last
  );
    logic [XLEN-1:0] v;
    if (addr == REG_ZERO) begin
      v = '0;
    end else if (addr == REG_IMM) begin
      v = imm_v;
    end else if (pend.we && pend.addr == addr) begin
      v = pend.data;
    end else if (last.we && last.addr == addr) begin
      v = last.data;
    end else if (vld) begin
      v = raw;
    end else begin
      v = '0;
    end
    return v;
  endfunction

  assign a_val = resolve(rs_r, raw_a, vld_a_r, imm, fwd, last_wb_r);
  assign b_val = resolve(rt_r, raw_b, vld_b_r, imm, fwd, last_wb_r);
  assign d_val = resolve(rd_r, raw_d, vld_d_r, imm, fwd, last_wb_r);

endmodule

[rtl/rxu_alu.sv]
// execute logic: arithmetic, shifts, branch decision and memory/io decode
// depends on rxu_pkg

module rxu_alu (
  input  logic [7:0]                  cmd,
  input  logic [rxu_pkg::REG_AW-1:0]  rd,
  input  logic [rxu_pkg::XLEN-1:0]    a,
  input  logic [rxu_pkg::XLEN-1:0]    b,
  input  logic [rxu_pkg::XLEN-1:0]    d,
  input  logic [rxu_pkg::PC_BITS-1:0] pc,
  output rxu_pkg::exec_t              ex
);
  import rxu_pkg::*;

  logic [XLEN-1:0] sum;
  logic [4:0]      sh;
  logic            cond;
  logic            is_branch;

  assign sum = a + b;
  assign sh  = b[4:0];

  always_comb begin
    ex          = '0;
    ex.rd       = rd;
    ex.next_pc  = pc;
    ex.sum      = sum;
    ex.io_ok    = (sum < XLEN'(IO_COUNT));
    cond        = 1'b0;
    is_branch   = 1'b0;
    unique case (op_t'(cmd))
      OP_ADD: begin ex.res = sum;     ex.rd_we = 1'b1; end
      OP_SUB: begin ex.res = a - b;   ex.rd_we = 1'b1; end
      OP_AND: begin ex.res = a & b;   ex.rd_we = 1'b1; end
      OP_OR:  begin ex.res = a | b;   ex.rd_we = 1'b1; end
      OP_XOR: begin ex.res = a ^ b;   ex.rd_we = 1'b1; end
      OP_MUL: begin ex.res = a * b;   ex.rd_we = 1'b1; end
      OP_SLL: begin ex.res = a << sh; ex.rd_we = 1'b1; end
      OP_SRA: begin ex.res = $unsigned($signed(a) >>> sh); ex.rd_we = 1'b1; end
      OP_SRL: begin ex.res = a >> sh; ex.rd_we = 1'b1; end
      OP_BEQ: begin is_branch = 1'b1; cond = (a == b); end
      OP_BNE: begin is_branch = 1'b1; cond = (a != b); end
      OP_BLT: begin is_branch = 1'b1; cond = ($signed(a) <  $signed(b)); end
      OP_BGT: begin is_branch = 1'b1; cond = ($signed(a) >  $signed(b)); end
      OP_BLE: begin is_branch = 1'b1; cond = ($signed(a) <= $signed(b)); end
      OP_BGE: begin is_branch = 1'b1; cond = ($signed(a) >= $signed(b)); end
      OP_JAL: begin
        ex.res     = XLEN'(pc);
        ex.rd      = RA_REG;
        ex.rd_we   = 1'b1;
        ex.next_pc = d[PC_BITS-1:0];
        ex.taken   = 1'b1;
      end
      OP_LW:   begin ex.is_load = 1'b1; ex.rd_we = 1'b1; end
      OP_SW:   ex.is_store = 1'b1;
      OP_RETI: begin ex.taken = 1'b1; ex.leave = 1'b1; end
      OP_IN:   begin ex.is_in = 1'b1; ex.rd_we = 1'b1; end
      OP_OUT:  ex.is_out = 1'b1;
      OP_HALT: ex.halted = 1'b1;
      default: ;
    endcase
    if (is_branch && cond) begin
      ex.next_pc = d[PC_BITS-1:0];
      ex.taken   = 1'b1;
    end
    // registers zero and immediate are never written
    if (ex.rd == REG_ZERO || ex.rd == REG_IMM) begin
      ex.rd_we = 1'b0;
    end
  end

endmodule

[rtl/risc_execute_unit_top.sv]
// top level of the execute unit: pipeline control, data and io memories
// depends on rxu_pkg, rxu_in_if, rxu_out_if, rxu_ram, rxu_regfile, rxu_alu
//
// usage
//   in_ch carries one decoded instruction per word; out_ch returns one
//   word per instruction with the next counter and the taken, halted and
//   interrupt-leave flags, in instruction order.
//   an accepted word is registered into the execute stage (register read,
//   execute), then into the output stage, where its result waits to leave.
//   throughput: one instruction per cycle while out_ch is ready; the
//   register file read, the data memory port and the io memory port each
//   serve one instruction per cycle, with forwarding between neighbours.
//   when out_ch stalls, the result waits in the output stage and one more
//   instruction is still taken into the execute stage; in_ch.ready drops
//   only when both are full.
//   after reset the data memory is swept to zero, one word a cycle, over
//   all MEM_WORDS words (4096 by default); in_ch.ready stays low meanwhile.
//   registers and io registers read as zero until written, through
//   valid bits cleared at reset.

module risc_execute_unit_top (
  input  logic     clk,
  input  logic     rst_n,
  rxu_in_if.sink   in_ch,
  rxu_out_if.source out_ch
);
  import rxu_pkg::*;

  // handshake and stage occupancy
  logic in_fire, out_fire, s1_move, s1_free, s2_free;
  logic s1_vld_r, s2_vld_r;

  // data memory clearing sweep
  logic              clr_busy_r;
  logic [MEM_AW-1:0] clr_cnt_r;

  // execute stage payload
  logic [7:0]         s1_cmd_r;
  logic [REG_AW-1:0]  s1_rd_r;
  logic [XLEN-1:0]    s1_imm_r;
  logic [PC_BITS-1:0] s1_pc_r;

  // output stage payload
  exec_t              s2_ex_r;
  logic               s2_io_vld_r;

  logic [XLEN-1:0] a_val, b_val, d_val;
  exec_t           ex;
  wb_t             fwd, wb;
  logic [XLEN-1:0] wb_data;

  // memories
  logic              dm_we, dm_re;
  logic [MEM_AW-1:0] dm_waddr;
  logic [XLEN-1:0]   dm_wdata, dm_rdata;
  logic              io_we, io_re, io_rd_ok;
  logic [IO_AW-1:0]  io_waddr, io_raddr;
  logic [XLEN-1:0]   io_rdata;
  logic [IO_COUNT-1:0] io_vld_r;

  // pipeline flow
  assign out_fire = s2_vld_r && out_ch.ready;
  assign s2_free  = !s2_vld_r || out_fire;
  assign s1_move  = s1_vld_r && s2_free;
  assign s1_free  = !s1_vld_r || s1_move;
  assign in_ch.ready = !clr_busy_r && s1_free;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      if (s1_free) begin
        s1_vld_r <= in_fire;
      end
      if (s2_free) begin
        s2_vld_r <= s1_move;
      end
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == MEM_AW'(MEM_WORDS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r <= in_ch.cmd;
      s1_rd_r  <= in_ch.dest_reg;
      s1_imm_r <= $unsigned(in_ch.immediate);
      s1_pc_r  <= in_ch.pc_value;
    end
    if (s1_move) begin
      s2_ex_r     <= ex;
      s2_io_vld_r <= io_rd_ok && io_vld_r[io_raddr];
    end
  end

  // register read happens in the accept cycle
  rxu_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rs_addr (in_ch.src_reg_a),
    .rt_addr (in_ch.src_reg_b),
    .rd_addr (in_ch.dest_reg),
    .imm     (s1_imm_r),
    .wb      (wb),
    .fwd     (fwd),
    .a_val   (a_val),
    .b_val   (b_val),
    .d_val   (d_val)
  );

  rxu_alu u_alu (
    .cmd (s1_cmd_r),
    .rd  (s1_rd_r),
    .a   (a_val),
    .b   (b_val),
    .d   (d_val),
    .pc  (s1_pc_r),
    .ex  (ex)
  );

  // data memory: the sweep owns the write port until it ends
  assign dm_we    = clr_busy_r || (s1_move && ex.is_store);
  assign dm_waddr = clr_busy_r ? clr_cnt_r : ex.sum[MEM_AW-1:0];
  assign dm_wdata = clr_busy_r ? '0 : d_val;
  assign dm_re    = s1_move && ex.is_load;

  rxu_ram #(.WIDTH(XLEN), .DEPTH(MEM_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (dm_re),
    .raddr (ex.sum[MEM_AW-1:0]),
    .rdata (dm_rdata)
  );

  // io registers; reti reads the return slot through the same port
  assign io_we    = s1_move && ex.is_out && ex.io_ok;
  assign io_waddr = ex.sum[IO_AW-1:0];
  assign io_re    = s1_move && (ex.is_in || ex.leave);
  assign io_raddr = ex.leave ? IRQ_RETURN_IO : ex.sum[IO_AW-1:0];
  assign io_rd_ok = ex.leave || ex.io_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_vld_r <= '0;
    end else if (io_we) begin
      io_vld_r[io_waddr] <= 1'b1;
    end
  end

  rxu_ram #(.WIDTH(XLEN), .DEPTH(IO_COUNT)) u_iomem (
    .clk   (clk),
    .we    (io_we),
    .waddr (io_waddr),
    .wdata (d_val),
    .re    (io_re),
    .raddr (io_raddr),
    .rdata (io_rdata)
  );

  // write-back value of the instruction in the output stage
  always_comb begin
    if (s2_ex_r.is_load) begin
      wb_data = dm_rdata;
    end else if (s2_ex_r.is_in) begin
      wb_data = s2_io_vld_r ? io_rdata : '0;
    end else begin
      wb_data = s2_ex_r.res;
    end
  end

  // pending write is forwarded; it lands in the file when the word leaves
  assign fwd.we   = s2_vld_r && s2_ex_r.rd_we;
  assign fwd.addr = s2_ex_r.rd;
  assign fwd.data = wb_data;
  assign wb.we    = out_fire && s2_ex_r.rd_we;
  assign wb.addr  = s2_ex_r.rd;
  assign wb.data  = wb_data;

  assign out_ch.valid           = s2_vld_r;
  assign out_ch.branch_taken    = s2_ex_r.taken;
  assign out_ch.halted          = s2_ex_r.halted;
  assign out_ch.leave_interrupt = s2_ex_r.leave;
  assign out_ch.next_pc = !s2_ex_r.leave ? s2_ex_r.next_pc :
                          s2_io_vld_r    ? io_rdata[PC_BITS-1:0] : '0;

endmodule

[sim/tb.sv]
// self-checking testbench for risc_execute_unit_top: random and directed instructions
// depends on rxu_pkg, rxu_in_if, rxu_out_if and the execute unit rtl
`timescale 1ns / 100ps

module tb;
  import rxu_pkg::*;

  // run shape
  localparam int N_RANDOM       = 750;
  localparam int CALM_FROM      = 650;   // no idling on either side from here on
  localparam int SQUEEZE_AT     = 200;   // random word index where the long hold-off starts
  localparam int SQUEEZE_CYCLES = 150;
  // longest quiet stretch is the memory sweep after reset or the squeeze
  localparam int WATCHDOG_LIMIT = 5 * (MEM_WORDS + SQUEEZE_CYCLES);
  localparam int DRAIN_CYCLES   = 8;
  localparam logic [7:0] CMD_UNUSED_TOP = 8'hFF;

  // one decoded instruction as driven on in_ch
  typedef struct packed {
    logic [7:0]         cmd;
    logic [REG_AW-1:0]  rd;
    logic [REG_AW-1:0]  rs;
    logic [REG_AW-1:0]  rt;
    logic [XLEN-1:0]    imm;
    logic [PC_BITS-1:0] pc;
  } instr_t;

  // one result word as seen on out_ch
  typedef struct packed {
    logic [PC_BITS-1:0] next_pc;
    logic               taken;
    logic               halted;
    logic               leave;
  } outcome_t;

  // architectural copy of the execute unit plus the queue of outcomes still owed
  class exec_scoreboard;
    bit [XLEN-1:0] gpr    [REG_COUNT];
    bit [XLEN-1:0] dmem   [MEM_WORDS];
    bit [XLEN-1:0] io_reg [IO_COUNT];
    outcome_t      owed_q [$];
    int            n_err;
    int            n_seen;

    function bit [XLEN-1:0] read_gpr(bit [REG_AW-1:0] r, bit [XLEN-1:0] imm);
      if (r == REG_ZERO) return '0;
      if (r == REG_IMM) return imm;
      return gpr[r];
    endfunction

    function void write_gpr(bit [REG_AW-1:0] r, bit [XLEN-1:0] v);
      if (r != REG_ZERO && r != REG_IMM) gpr[r] = v;
    endfunction

    // executes one accepted instruction and queues the outcome it must give
    function void note_instruction(instr_t w);
      bit [XLEN-1:0] a, b, d, sum;
      bit [4:0]      sh;
      bit            cond;
      outcome_t      o;
      a    = read_gpr(w.rs, w.imm);
      b    = read_gpr(w.rt, w.imm);
      d    = read_gpr(w.rd, w.imm);
      sum  = a + b;
      sh   = b[4:0];
      cond = 1'b0;
      o    = '{next_pc: w.pc, taken: 1'b0, halted: 1'b0, leave: 1'b0};
      case (w.cmd)
        OP_ADD:  write_gpr(w.rd, a + b);
        OP_SUB:  write_gpr(w.rd, a - b);
        OP_AND:  write_gpr(w.rd, a & b);
        OP_OR:   write_gpr(w.rd, a | b);
        OP_XOR:  write_gpr(w.rd, a ^ b);
        OP_MUL:  write_gpr(w.rd, a * b);
        OP_SLL:  write_gpr(w.rd, a << sh);
        OP_SRA:  write_gpr(w.rd, $signed(a) >>> sh);
        OP_SRL:  write_gpr(w.rd, a >> sh);
        OP_BEQ:  cond = (a == b);
        OP_BNE:  cond = (a != b);
        OP_BLT:  cond = ($signed(a) <  $signed(b));
        OP_BGT:  cond = ($signed(a) >  $signed(b));
        OP_BLE:  cond = ($signed(a) <= $signed(b));
        OP_BGE:  cond = ($signed(a) >= $signed(b));
        OP_JAL: begin
          // target is the old value of rd even when rd is the link register
          write_gpr(RA_REG, XLEN'(w.pc));
          o.next_pc = d[PC_BITS-1:0];
          o.taken   = 1'b1;
        end
        OP_LW:   write_gpr(w.rd, dmem[sum % MEM_WORDS]);
        OP_SW:   dmem[sum % MEM_WORDS] = d;
        OP_RETI: begin
          o.next_pc = io_reg[IRQ_RETURN_IO][PC_BITS-1:0];
          o.taken   = 1'b1;
          o.leave   = 1'b1;
        end
        OP_IN:   write_gpr(w.rd, (sum < IO_COUNT) ? io_reg[sum] : '0);
        OP_OUT:  if (sum < IO_COUNT) io_reg[sum] = d;
        OP_HALT: o.halted = 1'b1;
        default: ;
      endcase
      if (cond) begin
        o.next_pc = d[PC_BITS-1:0];
        o.taken   = 1'b1;
      end
      owed_q.push_back(o);
    endfunction

    task report(string what);
      n_err++;
      $display("%0t: mismatch: %s", $time, what);
    endtask

    task check_result(outcome_t got);
      outcome_t want;
      n_seen++;
      if (owed_q.size() == 0) begin
        report($sformatf("result %0d with nothing owed (next_pc %0h)", n_seen, got.next_pc));
        return;
      end
      want = owed_q.pop_front();
      if (got.next_pc !== want.next_pc)
        report($sformatf("result %0d next_pc %0h, want %0h", n_seen, got.next_pc, want.next_pc));
      if (got.taken !== want.taken)
        report($sformatf("result %0d branch_taken %b, want %b", n_seen, got.taken, want.taken));
      if (got.halted !== want.halted)
        report($sformatf("result %0d halted %b, want %b", n_seen, got.halted, want.halted));
      if (got.leave !== want.leave)
        report($sformatf("result %0d leave_interrupt %b, want %b", n_seen, got.leave,
                         want.leave));
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  rxu_in_if  in_ch ();
  rxu_out_if out_ch ();

  risc_execute_unit_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  exec_scoreboard sb = new;

  // idle percentages per side, changed window by window by the stimulus
  int src_idle_pct = 20;
  int snk_idle_pct = 20;
  bit squeeze_req  = 1'b0;
  bit squeeze_done = 1'b0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // every input known from time zero
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.cmd       = '0;
    in_ch.dest_reg  = '0;
    in_ch.src_reg_a = '0;
    in_ch.src_reg_b = '0;
    in_ch.immediate = '0;
    in_ch.pc_value  = '0;
    out_ch.ready    = 1'b0;
  end

  // offers one word and holds it until taken; an idle burst may follow
  task automatic send_word(instr_t w);
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= w.cmd;
    in_ch.dest_reg  <= w.rd;
    in_ch.src_reg_a <= w.rs;
    in_ch.src_reg_b <= w.rt;
    in_ch.immediate <= w.imm;
    in_ch.pc_value  <= w.pc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_instruction(w);
    // the gap drops valid in this step only; the next word raises it later
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic issue(logic [7:0] cmd, logic [REG_AW-1:0] rd, logic [REG_AW-1:0] rs,
                       logic [REG_AW-1:0] rt, logic [XLEN-1:0] imm, logic [PC_BITS-1:0] pc);
    send_word('{cmd: cmd, rd: rd, rs: rs, rt: rt, imm: imm, pc: pc});
  endtask

  // random instruction; memory and io accesses mostly aim at low addresses
  // through the immediate so that loads and ins find earlier stores
  function automatic instr_t random_instr();
    instr_t w;
    if ($urandom_range(0, 99) < 5)
      w.cmd = 8'($urandom_range(OP_HALT + 1, CMD_UNUSED_TOP));
    else
      w.cmd = 8'($urandom_range(OP_ADD, OP_HALT));
    w.rd = REG_AW'($urandom_range(0, REG_COUNT - 1));
    w.rs = REG_AW'($urandom_range(0, REG_COUNT - 1));
    w.rt = ($urandom_range(0, 3) == 0) ? w.rs : REG_AW'($urandom_range(0, REG_COUNT - 1));
    case ($urandom_range(0, 3))
      0:       w.imm = $urandom;
      1:       w.imm = $urandom_range(0, 31);
      2:       w.imm = 32'd0 - $urandom_range(1, 32);
      default: begin
        case ($urandom_range(0, 3))
          0:       w.imm = 32'h8000_0000;
          1:       w.imm = 32'h7FFF_FFFF;
          2:       w.imm = 32'hFFFF_FFFF;
          default: w.imm = 32'h0;
        endcase
      end
    endcase
    if ((w.cmd == OP_LW || w.cmd == OP_SW || w.cmd == OP_IN || w.cmd == OP_OUT) &&
        $urandom_range(0, 99) < 60) begin
      w.rs  = REG_IMM;
      w.rt  = REG_ZERO;
      w.imm = $urandom_range(0, IO_COUNT + 9);
    end
    w.pc = PC_BITS'($urandom_range(0, (1 << PC_BITS) - 1));
    return w;
  endfunction

  // result side: check each accepted word, then choose ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{next_pc: out_ch.next_pc, taken: out_ch.branch_taken,
                        halted: out_ch.halted, leave: out_ch.leave_interrupt});
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (squeeze_req && !squeeze_done) begin
      // long hold-off: the unit fills both stages and must drop in_ch.ready
      squeeze_done = 1'b1;
      hold_left    = SQUEEZE_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
      hold_left    = $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog: counts edges at which neither channel moves a word
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part; the unit takes nothing until its memory sweep is over
    issue(OP_ADD,  2,      REG_IMM,  REG_ZERO, 32'h8000_0000, 10'd0);    // r2 = most negative
    issue(OP_ADD,  REG_ZERO, REG_IMM, REG_IMM, 32'h7FFF_FFFF, 10'h3FF);  // write to zero dropped
    issue(OP_ADD,  REG_IMM, 2,       2,        32'd5,         10'd1);    // write to imm dropped
    issue(OP_SRA,  3,      2,        REG_IMM,  32'd33,        10'd2);    // shift by low five bits
    issue(OP_SRL,  4,      2,        REG_IMM,  32'hFFFF_FFE1, 10'd3);
    issue(OP_SLL,  5,      REG_IMM,  REG_IMM,  32'hFFFF_FFFF, 10'd4);    // shift by 31
    issue(OP_MUL,  6,      3,        REG_IMM,  32'hFFFF_FFFF, 10'd5);    // product wraps
    issue(OP_SUB,  7,      REG_ZERO, REG_IMM,  32'd1,         10'd6);    // r7 = -1
    issue(OP_AND,  8,      7,        REG_IMM,  32'h0000_FFFF, 10'd7);
    issue(OP_OR,   9,      8,        REG_IMM,  32'h00FF_0000, 10'd8);
    issue(OP_XOR,  10,     9,        REG_IMM,  32'h00FF_FD54, 10'd9);    // r10 = 0x2ab
    issue(OP_BEQ,  10,     2,        5,        32'd0,         10'd10);   // equal, taken
    issue(OP_BNE,  REG_IMM, 2,       5,        32'h155,       10'd11);   // not taken
    issue(OP_BLT,  10,     2,        7,        32'd0,         10'd12);   // signed: min < -1
    issue(OP_BGT,  10,     REG_IMM,  2,        32'h7FFF_FFFF, 10'd13);   // max > min
    issue(OP_BLE,  REG_IMM, 7,       7,        32'h0000_03FF, 10'd14);   // equal, target imm
    issue(OP_BGE,  10,     7,        REG_IMM,  32'd0,         10'd15);   // -1 >= 0 fails
    issue(OP_ADD,  RA_REG, 10,       REG_ZERO, 32'd0,         10'd16);
    issue(OP_JAL,  RA_REG, REG_ZERO, REG_ZERO, 32'd0,         10'h123);  // jumps to old link
    issue(OP_SW,   9,      REG_IMM,  REG_IMM,  32'h7FFF_FFFF, 10'd17);   // address wraps
    issue(OP_LW,   11,     REG_IMM,  REG_ZERO, 32'hFFFF_FFFE, 10'd18);   // same word back
    issue(OP_OUT,  10,     REG_ZERO, REG_IMM,  32'd7,         10'd19);   // return register
    issue(OP_OUT,  9,      REG_IMM,  REG_IMM,  32'd11,        10'd20);   // index 22, dropped
    issue(OP_IN,   12,     REG_IMM,  REG_ZERO, 32'hFFFF_FFFF, 10'd21);   // out of range reads 0
    issue(OP_RETI, 12,     REG_ZERO, REG_ZERO, 32'd0,         10'd22);
    issue(OP_HALT, 15,     15,       15,       32'hFFFF_FFFF, 10'd23);
    issue(CMD_UNUSED_TOP, 15, 15,    15,       32'hFFFF_FFFF, 10'h3FF);  // does nothing

    // random part, idling reshuffled every fifty words
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i >= CALM_FROM) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       src_idle_pct = 0;
          1:       src_idle_pct = 15;
          default: src_idle_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       snk_idle_pct = 0;
          1:       snk_idle_pct = 15;
          default: snk_idle_pct = 40;
        endcase
      end
      if (i == SQUEEZE_AT) begin
        // keep offering words while the receiver holds off
        src_idle_pct = 0;
        squeeze_req  = 1'b1;
      end
      send_word(random_instr());
    end
    in_ch.valid <= 1'b0;

    // drain: every owed word, then a few more edges to catch strays
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.n_err == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
